### rtl/acl_pkg.sv
// ----------------------------------------------------------------------------
// acl_pkg
// Shared types and constants of the access control list table.
// ----------------------------------------------------------------------------
package acl_pkg;

    localparam int MAX_ENTRIES  = 16;
    localparam int MAX_GROUPS   = 4;
    localparam int GROUP_FIELDS = 4;
    localparam int GROUP_LIMIT  = (MAX_GROUPS < GROUP_FIELDS) ? MAX_GROUPS : GROUP_FIELDS;

    localparam int ID_W     = 16;
    localparam int PERM_W   = 8;
    localparam int INDEX_W  = 4;
    localparam int GCOUNT_W = 3;
    localparam int HELD_W   = 5;

    localparam int ENTRY_AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int WIDE_W   = CNT_W + INDEX_W + 1;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } acl_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_SHIFT,
        S_DONE
    } acl_state_t;

    typedef struct packed {
        logic [1:0]          operation;
        logic [ID_W-1:0]     subject_id;
        logic                group_flag;
        logic                is_deny;
        logic [PERM_W-1:0]   perm_bits;
        logic [INDEX_W-1:0]  entry_index;
        logic [GCOUNT_W-1:0] group_count;
        logic [ID_W-1:0]     group_id_0;
        logic [ID_W-1:0]     group_id_1;
        logic [ID_W-1:0]     group_id_2;
        logic [ID_W-1:0]     group_id_3;
    } acl_in_t;

    typedef struct packed {
        logic              granted;
        logic              status;
        logic [HELD_W-1:0] entries_held;
    } acl_out_t;

    typedef struct packed {
        logic [PERM_W-1:0] perm;
        logic              deny;
        logic              group;
        logic [ID_W-1:0]   id;
    } acl_entry_t;

    typedef logic [GROUP_FIELDS-1:0][ID_W-1:0] acl_gids_t;

    typedef struct packed {
        logic [ID_W-1:0]     uid;
        acl_gids_t           gids;
        logic [GCOUNT_W-1:0] ngid;
    } acl_subject_t;

endpackage

### rtl/acl_in_if.sv
// ----------------------------------------------------------------------------
// acl_in_if
// Request channel: valid, ready and one request beat.
// ----------------------------------------------------------------------------
interface acl_in_if;

    logic              valid;
    logic              ready;
    acl_pkg::acl_in_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

### rtl/acl_out_if.sv
// ----------------------------------------------------------------------------
// acl_out_if
// Response channel: valid, ready and one response beat.
// ----------------------------------------------------------------------------
interface acl_out_if;

    logic              valid;
    logic              ready;
    acl_pkg::acl_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

### rtl/acl_match.sv
// ----------------------------------------------------------------------------
// acl_match
// Shared entry compare unit: tests one table entry against the checked
// user id or against the valid group ids.
// ----------------------------------------------------------------------------
module acl_match (
    input  acl_pkg::acl_entry_t   entry,
    input  acl_pkg::acl_subject_t subject,
    output logic                  hit
);
    import acl_pkg::*;

    logic grp_hit;

    always_comb
    begin
        grp_hit = 1'b0;
        for (int g = 0; g < GROUP_FIELDS; g++)
        begin
            if ((GCOUNT_W'(g) < subject.ngid) && (entry.id == subject.gids[g]))
            begin
                grp_hit = 1'b1;
            end
        end
        hit = entry.group ? grp_hit : (entry.id == subject.uid);
    end

endmodule

### rtl/acl_permission_table_core.sv
// ----------------------------------------------------------------------------
// acl_permission_table_core
// Access control list table with deny-overrides-allow checks.
// Check: the stored entries are walked from the request beat to the response,
//   one entry compared per cycle by the shared match unit.
// Remove: the entries above the index move down, one entry moved per cycle.
// Add, clear, rejected ops: go straight to the response state. One request at a time.
// Reset clears the entry count and the sequencer; no clearing pass.
// ----------------------------------------------------------------------------
module acl_permission_table_core (
    input  logic clk,
    input  logic rst_n,
    acl_in_if.sink    request,
    acl_out_if.source response
);
    import acl_pkg::*;

    acl_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ENTRY_AW-1:0]   idx_reg, idx_next;
    logic [PERM_W-1:0]     allow_reg, allow_next;
    logic [PERM_W-1:0]     deny_reg, deny_next;
    logic [PERM_W-1:0]     req_reg, req_next;
    acl_subject_t          subj_reg, subj_next;
    logic                  check_reg, check_next;
    logic                  status_reg, status_next;
    logic                  out_valid_reg, out_valid_next;
    acl_out_t              out_data_reg, out_data_next;

    acl_entry_t            table_mem [MAX_ENTRIES];
    logic                  wr_en;
    logic [ENTRY_AW-1:0]   wr_addr;
    acl_entry_t            wr_data;
    logic [ENTRY_AW-1:0]   rd_addr;
    acl_entry_t            rd_entry_reg;
    logic                  hit;
    logic [GCOUNT_W-1:0]   ngid_clamped;
    logic                  last_idx;
    logic                  load_out;

    assign rd_addr  = (state_next == S_SHIFT) ? ENTRY_AW'(idx_next + 1'b1) : idx_next;
    assign last_idx = (WIDE_W'(idx_reg) + WIDE_W'(1)) >= WIDE_W'(count_reg);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || response.ready);

    assign ngid_clamped = (request.data.group_count > GCOUNT_W'(GROUP_LIMIT))
                        ? GCOUNT_W'(GROUP_LIMIT) : request.data.group_count;

    acl_match u_match (
        .entry   (rd_entry_reg),
        .subject (subj_reg),
        .hit     (hit)
    );

    assign request.ready  = (state_reg == S_IDLE);
    assign response.valid = out_valid_reg;
    assign response.data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_entry_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        allow_reg    <= allow_next;
        deny_reg     <= deny_next;
        req_reg      <= req_next;
        subj_reg     <= subj_next;
        check_reg    <= check_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        allow_next     = allow_reg;
        deny_next      = deny_reg;
        req_next       = req_reg;
        subj_next      = subj_reg;
        check_next     = check_reg;
        status_next    = status_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !response.ready;
        wr_en          = 1'b0;
        wr_addr        = ENTRY_AW'(count_reg);
        wr_data        = rd_entry_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    check_next  = 1'b0;
                    status_next = 1'b0;
                    idx_next    = '0;
                    allow_next  = '0;
                    deny_next   = '0;
                    req_next    = request.data.perm_bits;
                    subj_next.uid  = request.data.subject_id;
                    subj_next.gids = {request.data.group_id_3, request.data.group_id_2,
                                      request.data.group_id_1, request.data.group_id_0};
                    subj_next.ngid = ngid_clamped;
                    state_next  = S_DONE;
                    case (acl_op_t'(request.data.operation))
                        OP_CHECK:
                        begin
                            check_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                allow_next = '1;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        OP_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_ENTRIES))
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                wr_en        = 1'b1;
                                wr_data.id    = request.data.subject_id;
                                wr_data.group = request.data.group_flag;
                                wr_data.deny  = request.data.is_deny;
                                wr_data.perm  = request.data.perm_bits;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (WIDE_W'(request.data.entry_index) >= WIDE_W'(count_reg))
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                idx_next   = ENTRY_AW'(request.data.entry_index);
                                state_next = S_SHIFT;
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (hit)
                begin
                    if (rd_entry_reg.deny)
                    begin
                        deny_next = deny_reg | rd_entry_reg.perm;
                    end
                    else
                    begin
                        allow_next = allow_reg | rd_entry_reg.perm;
                    end
                end
                idx_next = ENTRY_AW'(idx_reg + 1'b1);
                if (last_idx)
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                if (last_idx)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg;
                    wr_data  = rd_entry_reg;
                    idx_next = ENTRY_AW'(idx_reg + 1'b1);
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.granted      = check_reg &&
                                                 ((allow_reg & ~deny_reg & req_reg) == req_reg);
                    out_data_next.status       = status_reg;
                    out_data_next.entries_held = HELD_W'(count_reg);
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (WIDE_W'(idx_reg) < WIDE_W'(count_reg)))
        else $error("walk index beyond entry count");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("finished request not presented");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of acl_permission_table_core. A driver feeds request beats from a
// queue, a monitor predicts every response from a shadow copy of the access
// table and compares it field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    import acl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 700;
    localparam int MAX_PRINTS = 50;

    logic clk;
    logic rst_n;

    acl_in_if  request_if ();
    acl_out_if response_if ();

    acl_permission_table_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_if),
        .response (response_if)
    );

    acl_in_t    request_queue[$];
    acl_out_t   expected_replies[$];
    acl_entry_t shadow_table[MAX_ENTRIES];
    int         shadow_count;
    int         mismatch_count;
    int         cycle_count;
    logic [ID_W-1:0] id_pool[6];

    logic req_taken;
    logic rsp_taken;
    int   idle_left;
    int   stall_left;
    bit   src_calm;
    bit   snk_calm;

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0)
        begin
            calm = !calm;
        end
        if (calm)
        begin
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic acl_out_t compute_reply(acl_in_t req);
        acl_out_t          r;
        acl_entry_t        e;
        acl_gids_t         gids;
        logic [PERM_W-1:0] allow_bits;
        logic [PERM_W-1:0] deny_bits;
        int                ngroups;
        bit                hit;
        r = '0;
        allow_bits = '0;
        deny_bits = '0;
        gids = {req.group_id_3, req.group_id_2, req.group_id_1, req.group_id_0};
        ngroups = (req.group_count > GROUP_LIMIT) ? GROUP_LIMIT : int'(req.group_count);
        case (acl_op_t'(req.operation))
            OP_CHECK:
            begin
                if (shadow_count == 0)
                begin
                    r.granted = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < shadow_count; i++)
                    begin
                        e = shadow_table[i];
                        hit = 1'b0;
                        if (!e.group)
                        begin
                            hit = (e.id == req.subject_id);
                        end
                        else
                        begin
                            for (int g = 0; g < ngroups; g++)
                            begin
                                if (e.id == gids[g])
                                begin
                                    hit = 1'b1;
                                end
                            end
                        end
                        if (hit && e.deny)
                        begin
                            deny_bits |= e.perm;
                        end
                        else if (hit)
                        begin
                            allow_bits |= e.perm;
                        end
                    end
                    r.granted = ((allow_bits & ~deny_bits & req.perm_bits) == req.perm_bits);
                end
            end
            OP_ADD:
            begin
                if (shadow_count >= MAX_ENTRIES)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    e.perm  = req.perm_bits;
                    e.deny  = req.is_deny;
                    e.group = req.group_flag;
                    e.id    = req.subject_id;
                    shadow_table[shadow_count] = e;
                    shadow_count++;
                end
            end
            OP_REMOVE:
            begin
                if (req.entry_index >= shadow_count)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    for (int i = req.entry_index; i + 1 < shadow_count; i++)
                    begin
                        shadow_table[i] = shadow_table[i + 1];
                    end
                    shadow_count--;
                    shadow_table[shadow_count] = '0;
                end
            end
            default:
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    shadow_table[i] = '0;
                end
                shadow_count = 0;
            end
        endcase
        r.entries_held = shadow_count[HELD_W-1:0];
        return r;
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 4) == 0)
        begin
            return 16'($urandom_range(0, 65535));
        end
        return id_pool[$urandom_range(0, 5)];
    endfunction

    function automatic acl_in_t random_item(int mode);
        acl_in_t it;
        int      r;
        r = $urandom_range(0, 99);
        case (mode)
            0:       it.operation = (r < 55) ? OP_ADD : (r < 90) ? OP_CHECK :
                                    (r < 98) ? OP_REMOVE : OP_CLEAR;
            1:       it.operation = (r < 30) ? OP_ADD : (r < 75) ? OP_CHECK :
                                    (r < 97) ? OP_REMOVE : OP_CLEAR;
            default: it.operation = (r < 15) ? OP_ADD : (r < 55) ? OP_CHECK :
                                    (r < 98) ? OP_REMOVE : OP_CLEAR;
        endcase
        it.subject_id  = pick_id();
        it.group_flag  = 1'($urandom_range(0, 1));
        it.is_deny     = ($urandom_range(0, 3) == 0);
        it.perm_bits   = $urandom_range(0, 1) ? 8'(1 << $urandom_range(0, 7))
                                              : 8'($urandom_range(0, 255));
        it.entry_index = 4'($urandom_range(0, 15));
        it.group_count = 3'($urandom_range(0, 7));
        it.group_id_0  = pick_id();
        it.group_id_1  = pick_id();
        it.group_id_2  = pick_id();
        it.group_id_3  = pick_id();
        return it;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatch_count < MAX_PRINTS)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // monitor: sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        acl_out_t want;
        acl_out_t got;
        if (!rst_n)
        begin
            req_taken <= 1'b0;
            rsp_taken <= 1'b0;
        end
        else
        begin
            req_taken <= request_if.valid && request_if.ready;
            rsp_taken <= response_if.valid && response_if.ready;
            if (response_if.valid && response_if.ready)
            begin
                got = response_if.data;
                if (expected_replies.size() == 0)
                begin
                    report_mismatch("response beat with nothing expected");
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.granted !== want.granted)
                    begin
                        report_mismatch($sformatf("granted got %b want %b",
                                                  got.granted, want.granted));
                    end
                    if (got.status !== want.status)
                    begin
                        report_mismatch($sformatf("status got %b want %b",
                                                  got.status, want.status));
                    end
                    if (got.entries_held !== want.entries_held)
                    begin
                        report_mismatch($sformatf("entries_held got %0d want %0d",
                                                  got.entries_held, want.entries_held));
                    end
                end
            end
            if (request_if.valid && request_if.ready)
            begin
                expected_replies.push_back(compute_reply(request_if.data));
            end
        end
    end

    // driver: advance to the next beat once the current one is taken
    always @(negedge clk)
    begin
        acl_in_t next_item;
        if (!rst_n)
        begin
            request_if.valid <= 1'b0;
            idle_left <= 0;
        end
        else if (!request_if.valid || req_taken)
        begin
            if (idle_left > 0)
            begin
                request_if.valid <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (request_queue.size() > 0)
            begin
                next_item = request_queue.pop_front();
                request_if.data <= next_item;
                request_if.valid <= 1'b1;
                idle_left <= draw_wait(src_calm);
            end
            else
            begin
                request_if.valid <= 1'b0;
            end
        end
    end

    // response sink: hold ready low for a random stall after each beat
    always @(negedge clk)
    begin
        int n;
        if (!rst_n)
        begin
            response_if.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (rsp_taken)
        begin
            n = draw_wait(snk_calm);
            response_if.ready <= (n == 0);
            stall_left <= (n > 0) ? n - 1 : 0;
        end
        else if (stall_left > 0)
        begin
            response_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            response_if.ready <= 1'b1;
        end
    end

    initial
    begin
        acl_in_t it;
        int      mode;
        int      run_left;
        rst_n = 1'b0;
        request_if.valid = 1'b0;
        request_if.data = '0;
        response_if.ready = 1'b0;
        shadow_count = 0;
        mismatch_count = 0;
        cycle_count = 0;
        src_calm = 1'b0;
        snk_calm = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            shadow_table[i] = '0;
        end
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < 6; i++)
        begin
            id_pool[i] = 16'($urandom_range(0, 65535));
        end

        // empty table grants anything
        it = '0;
        it.operation = OP_CHECK;
        it.subject_id = 16'hFFFF;
        it.perm_bits = 8'hFF;
        request_queue.push_back(it);
        it = '0;
        it.operation = OP_ADD;
        it.subject_id = 16'hFFFF;
        it.perm_bits = 8'hFF;
        request_queue.push_back(it);
        it = '0;
        it.operation = OP_ADD;
        it.group_flag = 1'b1;
        it.is_deny = 1'b1;
        it.perm_bits = 8'h81;
        request_queue.push_back(it);
        // group count clamped; last group field names the deny group
        it = '0;
        it.operation = OP_CHECK;
        it.subject_id = 16'hFFFF;
        it.perm_bits = 8'h7E;
        it.group_count = 3'd7;
        it.group_id_0 = 16'hFFFF;
        it.group_id_1 = 16'hFFFF;
        it.group_id_2 = 16'hFFFF;
        request_queue.push_back(it);
        it.perm_bits = 8'hFF;
        request_queue.push_back(it);
        it.group_count = 3'd3;
        it.perm_bits = 8'h01;
        request_queue.push_back(it);
        it = '0;
        it.operation = OP_CHECK;
        request_queue.push_back(it);
        it = '0;
        it.operation = OP_REMOVE;
        it.entry_index = 4'd15;
        request_queue.push_back(it);
        for (int i = 0; i < MAX_ENTRIES - 2; i++)
        begin
            it = '0;
            it.operation = OP_ADD;
            it.subject_id = 16'(i * 4681);
            it.group_flag = i[0];
            it.is_deny = i[1];
            it.perm_bits = 8'(1 << (i % 8));
            request_queue.push_back(it);
        end
        // table full: add rejected
        it.subject_id = 16'h1234;
        request_queue.push_back(it);
        it = '0;
        it.operation = OP_CHECK;
        it.subject_id = 16'hFFFF;
        it.perm_bits = 8'h01;
        it.group_count = 3'd4;
        it.group_id_0 = 16'd4681;
        it.group_id_1 = 16'd14043;
        it.group_id_2 = 16'hFFFF;
        it.group_id_3 = 16'd23405;
        request_queue.push_back(it);
        it = '0;
        it.operation = OP_REMOVE;
        it.entry_index = 4'd15;
        request_queue.push_back(it);
        it.entry_index = 4'd0;
        request_queue.push_back(it);
        it = '0;
        it.operation = OP_CLEAR;
        request_queue.push_back(it);
        it = '0;
        it.operation = OP_CHECK;
        it.perm_bits = 8'hFF;
        request_queue.push_back(it);

        mode = 0;
        run_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (run_left == 0)
            begin
                mode = $urandom_range(0, 2);
                run_left = $urandom_range(20, 60);
            end
            run_left--;
            request_queue.push_back(random_item(mode));
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || request_if.valid)
        begin
            @(posedge clk);
        end
        while (expected_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

### files.f
rtl/acl_pkg.sv
rtl/acl_in_if.sv
rtl/acl_out_if.sv
rtl/acl_match.sv
rtl/acl_permission_table_core.sv
sim/tb_top.sv
